/* design/lmfe_pkg.sv */
// shared types, constants and functions of the led matrix frame encoder
package lmfe_pkg;

  localparam int MatrixSide = 5;
  localparam int LedCount   = MatrixSide * MatrixSide;
  localparam int IdxW       = $clog2(LedCount);
  localparam int SideW      = $clog2(MatrixSide);

  localparam int LevelW   = 8;
  localparam int ColorW   = 8;
  localparam int BrightW  = 9;
  localparam int ProdW    = ColorW + LevelW;
  localparam int FullW    = ProdW + BrightW;
  localparam int WordW    = 32;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 9;

  localparam logic [BrightW-1:0] BrightFull = BrightW'(256);
  localparam logic [ColorW-1:0]  ColorMax   = ColorW'(255);

  typedef enum logic [CfgIdxW-1:0] {
    REG_RED    = 2'd0,
    REG_GREEN  = 2'd1,
    REG_BLUE   = 2'd2,
    REG_BRIGHT = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    ST_LOAD  = 1'b0,
    ST_DRAIN = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic             wr_en;
    logic [IdxW-1:0]  wr_addr;
    logic             rd_en;
    logic [SideW-1:0] rd_row;
    logic [SideW-1:0] rd_rem;
    logic             rd_last;
  } lmfe_cmd_t;

  typedef struct packed {
    logic adv;
  } lmfe_status_t;

  // floor(x / 65280), capped at 255: drop the low byte, then exact divide by 255
  function automatic logic [ColorW-1:0] div_65280(input logic [FullW-1:0] x);
    logic [16:0] y;
    logic [17:0] t;
    logic [9:0]  q;
    y = x[FullW-1:8];
    t = {1'b0, y} + 18'(y[16:8]) + 18'd1;
    q = t[17:8];
    if (q > 10'(ColorMax)) begin
      return ColorMax;
    end
    return q[ColorW-1:0];
  endfunction

endpackage

/* design/lmfe_cell_if.sv */
// cell input channel
interface lmfe_cell_if;
  logic                          valid;
  logic                          ready;
  logic [lmfe_pkg::LevelW-1:0]   cell_level;

  modport source (output valid, output cell_level, input ready);
  modport sink   (input valid, input cell_level, output ready);
endinterface

/* design/lmfe_pixel_if.sv */
// pixel word output channel
interface lmfe_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [lmfe_pkg::WordW-1:0]  pixel_word;
  logic                        last_pixel;

  modport source (output valid, output pixel_word, output last_pixel, input ready);
  modport sink   (input valid, input pixel_word, input last_pixel, output ready);
endinterface

/* design/led_matrix_frame_encoder.sv */
// top level: serpentine grb pixel encoder for a 5x5 smart-led matrix
// cells load one per cycle while the encoder is loading; the 25th cell starts a drain of 25 words in led order
// after the 25th cell is accepted the drain starts and the first word of a frame is registered at the output
// words then leave one per cycle while the sink is ready (store read, two multiplies, output)
// next frame's cells are taken once the last store read is issued, while the last words are still in the pipeline
// reset clears the counters, the pipeline valid tags and sets colours to 255, brightness to 256
module led_matrix_frame_encoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lmfe_cell_if.sink                     cell_i,
  lmfe_pixel_if.source                  pixel_o,
  input  logic                          cfg_we_i,
  input  logic [lmfe_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lmfe_pkg::CfgDataW-1:0] cfg_data_i
);

  lmfe_pkg::lmfe_cmd_t    cmd;
  lmfe_pkg::lmfe_status_t status;

  lmfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cell_i.valid),
    .in_ready_o (cell_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lmfe_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cell_level_i (cell_i.cell_level),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (pixel_o.valid),
    .out_ready_i  (pixel_o.ready),
    .pixel_word_o (pixel_o.pixel_word),
    .last_pixel_o (pixel_o.last_pixel)
  );

endmodule

/* design/lmfe_ctrl.sv */
// controller: cell counting during load, led order sequencing during drain
module lmfe_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  lmfe_pkg::lmfe_status_t status_i,
  output lmfe_pkg::lmfe_cmd_t    cmd_o
);

  localparam logic [lmfe_pkg::IdxW-1:0]  CntLast = lmfe_pkg::IdxW'(lmfe_pkg::LedCount - 1);
  localparam logic [lmfe_pkg::SideW-1:0] SideMax = lmfe_pkg::SideW'(lmfe_pkg::MatrixSide - 1);

  lmfe_pkg::ctrl_state_e        state_q, state_d;
  logic [lmfe_pkg::IdxW-1:0]    cnt_q, cnt_d;
  logic [lmfe_pkg::SideW-1:0]   row_q, row_d;
  logic [lmfe_pkg::SideW-1:0]   rem_q, rem_d;
  logic                         last_led;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lmfe_pkg::ST_LOAD;
      cnt_q   <= '0;
      row_q   <= '0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      row_q   <= row_d;
      rem_q   <= rem_d;
    end
  end

  assign last_led = (row_q == '0) && (rem_q == SideMax);

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    row_d          = row_q;
    rem_d          = rem_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.wr_addr  = cnt_q;
    cmd_o.rd_row   = row_q;
    cmd_o.rd_rem   = rem_q;
    cmd_o.rd_last  = last_led;
    case (state_q)
      lmfe_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.wr_en = 1'b1;
          if (cnt_q == CntLast) begin
            cnt_d   = '0;
            row_d   = SideMax;
            rem_d   = '0;
            state_d = lmfe_pkg::ST_DRAIN;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      lmfe_pkg::ST_DRAIN: begin
        if (status_i.adv) begin
          cmd_o.rd_en = 1'b1;
          if (rem_q == SideMax) begin
            rem_d = '0;
            row_d = row_q - 1'b1;
          end else begin
            rem_d = rem_q + 1'b1;
          end
          if (last_led) begin
            state_d = lmfe_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_d = lmfe_pkg::ST_LOAD;
      end
    endcase
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntLast)
    else $error("cell count out of range");

  a_drain_cnt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lmfe_pkg::ST_DRAIN |-> cnt_q == '0)
    else $error("cell count not cleared during drain");

  a_drain_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lmfe_pkg::ST_LOAD && in_valid_i && cnt_q == CntLast)
    |=> (state_q == lmfe_pkg::ST_DRAIN && row_q == SideMax && rem_q == '0))
    else $error("drain did not start at first led");

endmodule

/* design/lmfe_datapath.sv */
// datapath: config registers, frame store, led mapping and channel scaling pipeline
module lmfe_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lmfe_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [lmfe_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic [lmfe_pkg::LevelW-1:0]        cell_level_i,
  input  lmfe_pkg::lmfe_cmd_t                cmd_i,
  output lmfe_pkg::lmfe_status_t             status_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [lmfe_pkg::WordW-1:0]         pixel_word_o,
  output logic                               last_pixel_o
);

  localparam logic [lmfe_pkg::SideW-1:0] SideMax = lmfe_pkg::SideW'(lmfe_pkg::MatrixSide - 1);

  logic [lmfe_pkg::ColorW-1:0]  red_q, green_q, blue_q;
  logic [lmfe_pkg::BrightW-1:0] bright_q;
  logic [lmfe_pkg::BrightW-1:0] bright_sat;

  logic [lmfe_pkg::LevelW-1:0]  mem [lmfe_pkg::LedCount];

  logic                         adv;
  logic [lmfe_pkg::SideW-1:0]   col;
  logic [lmfe_pkg::IdxW-1:0]    rd_addr;

  logic                         v1_q, v2_q, v3_q, out_valid_q;
  logic                         last1_q, last2_q, last3_q, last_q;
  logic [lmfe_pkg::LevelW-1:0]  level_q;
  logic [lmfe_pkg::ProdW-1:0]   mr_q, mg_q, mb_q;
  logic [lmfe_pkg::FullW-1:0]   pr_q, pg_q, pb_q;
  logic [lmfe_pkg::WordW-1:0]   word_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q    <= lmfe_pkg::ColorMax;
      green_q  <= lmfe_pkg::ColorMax;
      blue_q   <= lmfe_pkg::ColorMax;
      bright_q <= lmfe_pkg::BrightFull;
    end else if (cfg_we_i) begin
      case (lmfe_pkg::cfg_reg_e'(cfg_idx_i))
        lmfe_pkg::REG_RED:    red_q    <= cfg_data_i[lmfe_pkg::ColorW-1:0];
        lmfe_pkg::REG_GREEN:  green_q  <= cfg_data_i[lmfe_pkg::ColorW-1:0];
        lmfe_pkg::REG_BLUE:   blue_q   <= cfg_data_i[lmfe_pkg::ColorW-1:0];
        lmfe_pkg::REG_BRIGHT: bright_q <= cfg_data_i[lmfe_pkg::BrightW-1:0];
        default: ;
      endcase
    end
  end

  assign bright_sat = (bright_q > lmfe_pkg::BrightFull) ? lmfe_pkg::BrightFull : bright_q;

  // pipeline moves whenever the output register is free or being taken
  assign adv          = !out_valid_q || out_ready_i;
  assign status_o.adv = adv;

  // serpentine mapping, column mirrored on even rows
  assign col     = cmd_i.rd_row[0] ? cmd_i.rd_rem : (SideMax - cmd_i.rd_rem);
  assign rd_addr = lmfe_pkg::IdxW'(lmfe_pkg::IdxW'(cmd_i.rd_row)
                   * lmfe_pkg::IdxW'(lmfe_pkg::MatrixSide) + lmfe_pkg::IdxW'(col));

  // frame store
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[cmd_i.wr_addr] <= cell_level_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && cmd_i.rd_en) begin
      level_q <= mem[rd_addr];
    end
  end

  // valid and last tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
      last1_q     <= 1'b0;
      last2_q     <= 1'b0;
      last3_q     <= 1'b0;
      last_q      <= 1'b0;
    end else if (adv) begin
      v1_q        <= cmd_i.rd_en;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
      last1_q     <= cmd_i.rd_en && cmd_i.rd_last;
      last2_q     <= last1_q;
      last3_q     <= last2_q;
      last_q      <= last3_q;
    end
  end

  // colour times level, then times brightness, then divide and pack
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mr_q   <= lmfe_pkg::ProdW'(red_q) * lmfe_pkg::ProdW'(level_q);
      mg_q   <= lmfe_pkg::ProdW'(green_q) * lmfe_pkg::ProdW'(level_q);
      mb_q   <= lmfe_pkg::ProdW'(blue_q) * lmfe_pkg::ProdW'(level_q);
      pr_q   <= lmfe_pkg::FullW'(mr_q) * lmfe_pkg::FullW'(bright_sat);
      pg_q   <= lmfe_pkg::FullW'(mg_q) * lmfe_pkg::FullW'(bright_sat);
      pb_q   <= lmfe_pkg::FullW'(mb_q) * lmfe_pkg::FullW'(bright_sat);
      word_q <= {lmfe_pkg::div_65280(pg_q), lmfe_pkg::div_65280(pr_q),
                 lmfe_pkg::div_65280(pb_q), 8'h00};
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_word_o = word_q;
  assign last_pixel_o = last_q;

endmodule

/* verif/tb_led_matrix_frame_encoder.sv */
// testbench for the led matrix frame encoder: directed and random cell frames checked against a frame predictor
module tb_led_matrix_frame_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod  = 4;
  localparam int ResetWait  = 11;
  localparam int DrainSlack = 16;
  localparam int HoldCycles = 300;
  localparam int TimeoutNs  = 2_000_000;

  typedef struct {
    logic [lmfe_pkg::WordW-1:0] word;
    logic                       last;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                          cfg_we_i;
  logic [lmfe_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [lmfe_pkg::CfgDataW-1:0] cfg_data_i;

  lmfe_cell_if  cell_bus ();
  lmfe_pixel_if pix_bus ();

  led_matrix_frame_encoder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cell_i     (cell_bus),
    .pixel_o    (pix_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  logic [lmfe_pkg::LevelW-1:0] pending_cells[$];
  pixel_t                      expected_pixels[$];

  logic [lmfe_pkg::LevelW-1:0] frame_cells[lmfe_pkg::LedCount];
  int                          cells_in_frame;
  logic [7:0]                  red_level;
  logic [7:0]                  green_level;
  logic [7:0]                  blue_level;
  logic [8:0]                  bright_q8;

  int send_idle_pct;
  int stall_pct;
  int hold_left;
  int error_count;

  function automatic logic [7:0] scale_level(input int unsigned colour,
                                             input int unsigned lvl,
                                             input int unsigned br);
    int unsigned v;
    v = (colour * lvl * br) / 65280;
    return (v > 255) ? 8'hFF : v[7:0];
  endfunction

  // serpentine mapping from led order to frame cell, then grb packing
  function automatic void encode_frame();
    int     row;
    int     col;
    int     pos;
    int     br;
    pixel_t px;
    br = (bright_q8 > 9'd256) ? 256 : int'(bright_q8);
    for (int led = 0; led < lmfe_pkg::LedCount; led++) begin
      row = lmfe_pkg::MatrixSide - 1 - led / lmfe_pkg::MatrixSide;
      col = lmfe_pkg::MatrixSide - 1 - led % lmfe_pkg::MatrixSide;
      if (row % 2 == 1) begin
        col = lmfe_pkg::MatrixSide - 1 - col;
      end
      pos = row * lmfe_pkg::MatrixSide + col;
      px.word = {scale_level(green_level, frame_cells[pos], br),
                 scale_level(red_level, frame_cells[pos], br),
                 scale_level(blue_level, frame_cells[pos], br),
                 8'h00};
      px.last = (led == lmfe_pkg::LedCount - 1);
      expected_pixels.push_back(px);
    end
  endfunction

  function automatic void take_cell(input logic [lmfe_pkg::LevelW-1:0] lvl);
    frame_cells[cells_in_frame] = lvl;
    cells_in_frame++;
    if (cells_in_frame == lmfe_pkg::LedCount) begin
      cells_in_frame = 0;
      encode_frame();
    end
  endfunction

  // cell driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_bus.valid <= 1'b0;
    end else begin
      if (cell_bus.valid && cell_bus.ready) begin
        take_cell(cell_bus.cell_level);
      end
      if (!(cell_bus.valid && !cell_bus.ready)) begin
        if (pending_cells.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cell_bus.valid      <= 1'b1;
          cell_bus.cell_level <= pending_cells.pop_front();
        end else begin
          cell_bus.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_bus.ready <= 1'b0;
    end else begin
      pix_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  // pixel monitor
  always @(posedge clk_i) begin : pixel_check
    pixel_t want;
    if (rst_ni && pix_bus.valid && pix_bus.ready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel item: pixel_word %h last_pixel %b",
               pix_bus.pixel_word, pix_bus.last_pixel);
        error_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (pix_bus.pixel_word !== want.word) begin
          $error("pixel_word: expected %h, actual %h", want.word, pix_bus.pixel_word);
          error_count++;
        end
        if (pix_bus.last_pixel !== want.last) begin
          $error("last_pixel: expected %b, actual %b", want.last, pix_bus.last_pixel);
          error_count++;
        end
      end
    end
  end

  task automatic write_reg(input lmfe_pkg::cfg_reg_e idx,
                           input logic [lmfe_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      lmfe_pkg::REG_RED:    red_level   = data[7:0];
      lmfe_pkg::REG_GREEN:  green_level = data[7:0];
      lmfe_pkg::REG_BLUE:   blue_level  = data[7:0];
      lmfe_pkg::REG_BRIGHT: bright_q8   = data;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_cells.size() != 0 || cell_bus.valid || expected_pixels.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainSlack) @(posedge clk_i);
  endtask

  function automatic logic [lmfe_pkg::LevelW-1:0] rand_level();
    if ($urandom_range(7) == 0) begin
      return ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
    end
    return lmfe_pkg::LevelW'($urandom_range(255));
  endfunction

  task automatic run_frames(input int red, input int green, input int blue, input int bright,
                            input int frames, input int send_pct, input int rx_pct,
                            input bit pressure);
    write_reg(lmfe_pkg::REG_RED, lmfe_pkg::CfgDataW'(red));
    write_reg(lmfe_pkg::REG_GREEN, lmfe_pkg::CfgDataW'(green));
    write_reg(lmfe_pkg::REG_BLUE, lmfe_pkg::CfgDataW'(blue));
    write_reg(lmfe_pkg::REG_BRIGHT, lmfe_pkg::CfgDataW'(bright));
    send_idle_pct = send_pct;
    stall_pct     = rx_pct;
    @(posedge clk_i);
    for (int n = 0; n < frames * lmfe_pkg::LedCount; n++) begin
      pending_cells.push_back(rand_level());
    end
    if (pressure) begin
      hold_left <= HoldCycles;
    end
    wait_drained();
  endtask

  initial begin
    #(TimeoutNs);
    $display("FAIL led_matrix_frame_encoder");
    $finish;
  end

  initial begin
    logic [lmfe_pkg::LevelW-1:0] corner_cells[lmfe_pkg::LedCount];
    corner_cells = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'h10,
                     8'h20, 8'h30, 8'h40, 8'h50, 8'h60, 8'h70, 8'h90, 8'hA0, 8'hB0,
                     8'hC0, 8'hD0, 8'hE0, 8'hF0, 8'h08, 8'h04, 8'h02};
    rst_ni              = 1'b0;
    cell_bus.valid      = 1'b0;
    cell_bus.cell_level = '0;
    pix_bus.ready       = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = lmfe_pkg::REG_RED;
    cfg_data_i          = '0;
    hold_left           = 0;
    send_idle_pct       = 0;
    stall_pct           = 0;
    error_count         = 0;
    cells_in_frame      = 0;
    red_level           = 8'hFF;
    green_level         = 8'hFF;
    blue_level          = 8'hFF;
    bright_q8           = 9'd256;
    repeat (ResetWait) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset colours and brightness, distinct levels expose the led order
    foreach (corner_cells[k]) begin
      pending_cells.push_back(corner_cells[k]);
    end
    wait_drained();

    // brightness above full saturates; other runs use zero, full and unit brightness
    run_frames(0, 255, 1, 511, 1, 85, 0, 1'b0);
    run_frames(255, 0, 128, 0, 1, 0, 85, 1'b0);
    run_frames($urandom_range(255), $urandom_range(255), $urandom_range(255), 257,
               1, 36, 36, 1'b0);
    run_frames(255, 255, 255, 256, 2, 0, 0, 1'b1);
    run_frames(1, 1, 1, 1, 1, 85, 0, 1'b0);

    if (error_count == 0) begin
      $display("PASS led_matrix_frame_encoder");
    end else begin
      $display("FAIL led_matrix_frame_encoder");
    end
    $finish;
  end

endmodule

/* sim.f */
design/lmfe_pkg.sv
design/lmfe_cell_if.sv
design/lmfe_pixel_if.sv
design/lmfe_ctrl.sv
design/lmfe_datapath.sv
design/led_matrix_frame_encoder.sv
verif/tb_led_matrix_frame_encoder.sv
